FILE: rtl/maze_carver_dfs_top_macros.svh
// Assertion macros shared by the maze carver RTL.
`ifndef MAZE_CARVER_DFS_TOP_MACROS_SVH
`define MAZE_CARVER_DFS_TOP_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define MCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define MCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/mcd_pkg.sv
// Constants and types of the maze carver.
package mcd_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int X_W     = $clog2(MAX_COLUMNS);
  localparam int Y_W     = $clog2(MAX_ROWS);
  localparam int NX_W    = X_W + 1;
  localparam int NY_W    = Y_W + 1;
  localparam int HX_W    = X_W - 1;
  localparam int HY_W    = Y_W - 1;
  localparam int ENTRY_W = HX_W + HY_W;

  localparam int CFG_W  = 7;
  localparam int RND_W  = 8;
  localparam int OUT_W  = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int LIM_W_XY = (NX_W > NY_W) ? NX_W : NY_W;
  localparam int LIM_W    = (CFG_W > LIM_W_XY) ? CFG_W : LIM_W_XY;

  localparam int STACK_DEPTH = ((MAX_COLUMNS + 1) / 2) * ((MAX_ROWS + 1) / 2);
  localparam int SP_AW       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int CELLS   = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_AW = $clog2(CELLS);

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_CARVED  = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_NOSTART = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_e;

endpackage

FILE: rtl/maze_carver_dfs_top.sv
// Maze carver top level: randomized depth-first search over an open-cell map.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------------------
//  command   | in        | start high, busy low          | command_i, random_value_i
//  result    | out       | result_valid_o, one cycle      | kind_o, target_x/y_o, between_x/y_o
//  config    | in/out    | APB setup + access, pready = 1 | paddr, pwdata, prdata
//
// Start beat: clears the 4096-cell open map one cell a cycle, then opens (1,1).
// Step beat: for each stack entry examined, pop, load, four map probes, evaluate and pick,
// then carve; the single read port of the open-map RAM sets the probe count.
// Step before any start, or with an empty stack, answers in the cycle after it is accepted.
// Reset clears the control state and sets both size registers to 64; the results cannot be
// held off by the receiver, and busy stays high until a beat's result is out.
`include "maze_carver_dfs_top_macros.svh"

module maze_carver_dfs_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command_i,
  input  logic [mcd_pkg::RND_W-1:0]           random_value_i,
  output logic                                result_valid_o,
  output logic [1:0]                          kind_o,
  output logic [mcd_pkg::OUT_W-1:0]           target_x_o,
  output logic [mcd_pkg::OUT_W-1:0]           target_y_o,
  output logic [mcd_pkg::OUT_W-1:0]           between_x_o,
  output logic [mcd_pkg::OUT_W-1:0]           between_y_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcd_pkg::PADDR_W-1:0]         paddr,
  input  logic [mcd_pkg::PDATA_W-1:0]         pwdata,
  output logic [mcd_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int XW      = mcd_pkg::X_W;
  localparam int YW      = mcd_pkg::Y_W;
  localparam int HXW     = mcd_pkg::HX_W;
  localparam int HYW     = mcd_pkg::HY_W;
  localparam int LimW    = mcd_pkg::LIM_W;
  localparam int CellAw  = mcd_pkg::CELL_AW;
  localparam int SpAw    = mcd_pkg::SP_AW;
  localparam int CntW    = mcd_pkg::CNT_W;
  localparam int CfgW    = mcd_pkg::CFG_W;
  localparam int OutW    = mcd_pkg::OUT_W;
  localparam int MaxCols = mcd_pkg::MAX_COLUMNS;
  localparam int MaxRows = mcd_pkg::MAX_ROWS;
  localparam int Depth   = mcd_pkg::STACK_DEPTH;
  localparam int Cells   = mcd_pkg::CELLS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_INIT  = 9'b000000100,
    S_POP   = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_PROBE = 9'b000100000,
    S_EVAL  = 9'b001000000,
    S_PICK  = 9'b010000000,
    S_CARVE = 9'b100000000
  } state_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic [LimW-1:0] size_lim(input logic [CfgW-1:0] v, input int maxv);
    logic [LimW-1:0] s;
    s = LimW'(v);
    if (s < LimW'(3)) begin
      s = LimW'(3);
    end else if (s > LimW'(maxv)) begin
      s = LimW'(maxv);
    end
    return s - LimW'(1);
  endfunction

  // residue mod 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(input logic [mcd_pkg::RND_W-1:0] v);
    logic [3:0] s4;
    logic [2:0] s3;
    s4 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    s3 = 3'(s4[3:2]) + 3'(s4[1:0]);
    if (s3 >= 3'd6) begin
      return 2'd0;
    end else if (s3 >= 3'd3) begin
      return 2'(s3 - 3'd3);
    end
    return s3[1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  state_e                state_q, state_d;
  logic [CfgW-1:0]       cols_q, rows_q;
  logic                  started_q, started_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [mcd_pkg::RND_W-1:0] rnd_q, rnd_d;
  logic [CellAw-1:0]     clr_q, clr_d;
  logic [HXW-1:0]        cur_hx_q, cur_hx_d;
  logic [HYW-1:0]        cur_hy_q, cur_hy_d;
  mcd_pkg::dir_e         dir_q, dir_d;
  mcd_pkg::dir_e         sel_dir_q, sel_dir_d;
  logic                  rd_pend_q, rd_pend_d;
  mcd_pkg::dir_e         rd_dir_q, rd_dir_d;
  logic                  inb_q, inb_d;
  logic [3:0]            cand_q;
  logic                  cand_clr;
  logic [XW-1:0]         tgt_x_q, tgt_x_d;
  logic [YW-1:0]         tgt_y_q, tgt_y_d;

  logic                  res_vld_q;
  mcd_pkg::kind_e        kind_q;
  logic [OutW-1:0]       tx_q, ty_q, bx_q, by_q;

  logic                  emit;
  mcd_pkg::kind_e        emit_kind;
  logic [OutW-1:0]       emit_tx, emit_ty, emit_bx, emit_by;

  // ---------------------------------------------------------------- memories
  logic                  m_we, m_wdata, m_re, m_rdata;
  logic [CellAw-1:0]     m_waddr, m_raddr;
  logic                  s_we, s_re;
  logic [SpAw-1:0]       s_waddr, s_raddr;
  logic [HXW+HYW-1:0]    s_wdata, s_rdata;

  mcd_ram #(.WIDTH(1), .DEPTH(Cells)) u_open_map (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  mcd_ram #(.WIDTH(HXW + HYW), .DEPTH(Depth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // ---------------------------------------------------------------- config port
  logic cfg_wr;
  mcd_pkg::reg_e cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mcd_pkg::reg_e'(paddr[mcd_pkg::PADDR_W-1]);
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == mcd_pkg::REG_ROWS) ? mcd_pkg::PDATA_W'(rows_q)
                                                  : mcd_pkg::PDATA_W'(cols_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CfgW'(64);
      rows_q <= CfgW'(64);
    end else if (cfg_wr) begin
      if (cfg_idx == mcd_pkg::REG_ROWS) begin
        rows_q <= pwdata[CfgW-1:0];
      end else begin
        cols_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- shared neighbor unit
  // one add/subtract and border compare, reused for probes, target and wall cell
  mcd_pkg::dir_e   u_dir;
  logic            u_far;
  logic            u_vert, u_minus, u_ok;
  logic [LimW-1:0] lim_x, lim_y, u_base, u_other, u_lim, u_olim, u_dist, u_m;
  logic [XW-1:0]   cur_x, u_x;
  logic [YW-1:0]   cur_y, u_y;
  logic [CellAw-1:0] u_addr;

  assign lim_x = size_lim(cols_q, MaxCols);
  assign lim_y = size_lim(rows_q, MaxRows);
  assign cur_x = {cur_hx_q, 1'b1};
  assign cur_y = {cur_hy_q, 1'b1};

  always_comb begin
    u_vert  = (u_dir == mcd_pkg::DIR_UP) || (u_dir == mcd_pkg::DIR_DOWN);
    u_minus = (u_dir == mcd_pkg::DIR_UP) || (u_dir == mcd_pkg::DIR_LEFT);
    u_dist  = u_far ? LimW'(2) : LimW'(1);
    u_base  = u_vert ? LimW'(cur_y) : LimW'(cur_x);
    u_other = u_vert ? LimW'(cur_x) : LimW'(cur_y);
    u_lim   = u_vert ? lim_y : lim_x;
    u_olim  = u_vert ? lim_x : lim_y;
    u_m     = u_minus ? (u_base - u_dist) : (u_base + u_dist);
    u_ok    = (!u_minus || (u_base > u_dist)) && (u_m < u_lim) &&
              (u_other != '0) && (u_other < u_olim);
    u_x     = u_vert ? cur_x : XW'(u_m);
    u_y     = u_vert ? YW'(u_m) : cur_y;
    u_addr  = CellAw'(u_y) * CellAw'(MaxCols) + CellAw'(u_x);
  end

  // ---------------------------------------------------------------- candidate pick
  logic [2:0]    cand_n;
  logic [1:0]    pick_k, seen;
  mcd_pkg::dir_e pick_dir;

  always_comb begin
    cand_n = 3'(cand_q[0]) + 3'(cand_q[1]) + 3'(cand_q[2]) + 3'(cand_q[3]);
    case (cand_n)
      3'd2:    pick_k = {1'b0, rnd_q[0]};
      3'd3:    pick_k = mod3(rnd_q);
      3'd4:    pick_k = rnd_q[1:0];
      default: pick_k = 2'd0;
    endcase
    pick_dir = mcd_pkg::DIR_UP;
    seen     = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_q[i] && (seen == pick_k)) begin
        pick_dir = mcd_pkg::dir_e'(i[1:0]);
      end
      if (cand_q[i]) begin
        seen = seen + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic accept;
  logic push_room;

  assign accept    = start && (state_q == S_IDLE);
  assign push_room = (count_q + CntW'(1)) < CntW'(Depth);

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    count_d   = count_q;
    rnd_d     = rnd_q;
    clr_d     = clr_q;
    cur_hx_d  = cur_hx_q;
    cur_hy_d  = cur_hy_q;
    dir_d     = dir_q;
    sel_dir_d = sel_dir_q;
    tgt_x_d   = tgt_x_q;
    tgt_y_d   = tgt_y_q;
    rd_pend_d = 1'b0;
    rd_dir_d  = rd_dir_q;
    inb_d     = inb_q;
    cand_clr  = 1'b0;

    u_dir = dir_q;
    u_far = 1'b1;

    m_we    = 1'b0;
    m_waddr = u_addr;
    m_wdata = 1'b1;
    m_re    = 1'b0;
    m_raddr = u_addr;
    s_we    = 1'b0;
    s_waddr = count_q[SpAw-1:0];
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = SpAw'(count_q - CntW'(1));

    emit      = 1'b0;
    emit_kind = mcd_pkg::KIND_DONE;
    emit_tx   = '0;
    emit_ty   = '0;
    emit_bx   = '0;
    emit_by   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rnd_d = random_value_i;
          if (mcd_pkg::cmd_e'(command_i) == mcd_pkg::CMD_START) begin
            clr_d   = '0;
            count_d = '0;
            state_d = S_CLEAR;
          end else if (!started_q) begin
            emit      = 1'b1;
            emit_kind = mcd_pkg::KIND_NOSTART;
          end else if (count_q == '0) begin
            emit      = 1'b1;
            emit_kind = mcd_pkg::KIND_DONE;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = 1'b0;
        clr_d   = clr_q + CellAw'(1);
        if (clr_q == CellAw'(Cells - 1)) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        m_we      = 1'b1;
        m_waddr   = CellAw'(MaxCols + 1);
        s_we      = 1'b1;
        s_waddr   = '0;
        s_wdata   = '0;
        count_d   = CntW'(1);
        started_d = 1'b1;
        emit      = 1'b1;
        emit_kind = mcd_pkg::KIND_START;
        emit_tx   = OutW'(1);
        emit_ty   = OutW'(1);
        state_d   = S_IDLE;
      end
      S_POP: begin
        s_re    = 1'b1;
        count_d = count_q - CntW'(1);
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cur_hx_d = s_rdata[HXW-1:0];
        cur_hy_d = s_rdata[HXW+HYW-1:HXW];
        dir_d    = mcd_pkg::DIR_UP;
        cand_clr = 1'b1;
        state_d  = S_PROBE;
      end
      S_PROBE: begin
        m_re      = 1'b1;
        rd_pend_d = 1'b1;
        rd_dir_d  = dir_q;
        inb_d     = u_ok;
        dir_d     = mcd_pkg::dir_e'(dir_q + 2'd1);
        if (dir_q == mcd_pkg::DIR_RIGHT) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // last probe's candidate bit is captured at the end of this cycle
        state_d = S_PICK;
      end
      S_PICK: begin
        u_dir = pick_dir;
        if (cand_q == 4'd0) begin
          if (count_q == '0) begin
            emit      = 1'b1;
            emit_kind = mcd_pkg::KIND_DONE;
            state_d   = S_IDLE;
          end else begin
            state_d = S_POP;
          end
        end else begin
          // current entry still sits at count_q: restoring the count re-pushes it
          m_we      = 1'b1;
          s_we      = push_room;
          s_waddr   = SpAw'(count_q + CntW'(1));
          s_wdata   = {u_y[YW-1:1], u_x[XW-1:1]};
          count_d   = count_q + (push_room ? CntW'(2) : CntW'(1));
          sel_dir_d = pick_dir;
          tgt_x_d   = u_x;
          tgt_y_d   = u_y;
          state_d   = S_CARVE;
        end
      end
      S_CARVE: begin
        u_dir     = sel_dir_q;
        u_far     = 1'b0;
        m_we      = 1'b1;
        emit      = 1'b1;
        emit_kind = mcd_pkg::KIND_CARVED;
        emit_tx   = OutW'(tgt_x_q);
        emit_ty   = OutW'(tgt_y_q);
        emit_bx   = OutW'(u_x);
        emit_by   = OutW'(u_y);
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      res_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q     <= rnd_d;
    clr_q     <= clr_d;
    cur_hx_q  <= cur_hx_d;
    cur_hy_q  <= cur_hy_d;
    dir_q     <= dir_d;
    sel_dir_q <= sel_dir_d;
    tgt_x_q   <= tgt_x_d;
    tgt_y_q   <= tgt_y_d;
    rd_dir_q  <= rd_dir_d;
    inb_q     <= inb_d;
    if (cand_clr) begin
      cand_q <= 4'd0;
    end else if (rd_pend_q) begin
      cand_q[rd_dir_q] <= inb_q && !m_rdata;
    end
    if (emit) begin
      kind_q <= emit_kind;
      tx_q   <= emit_tx;
      ty_q   <= emit_ty;
      bx_q   <= emit_bx;
      by_q   <= emit_by;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign kind_o         = kind_q;
  assign target_x_o     = tx_q;
  assign target_y_o     = ty_q;
  assign between_x_o    = bx_q;
  assign between_y_o    = by_q;

  // ---------------------------------------------------------------- assertions
  `MCD_ASSERT(a_count_bound, count_q <= CntW'(Depth), "stack count beyond stack depth")
  `MCD_ASSERT_IMP(a_beat_idle, res_vld_q, !busy, "result beat while sequencer busy")
  `MCD_ASSERT_IMP(a_carve_started, res_vld_q && (kind_q == mcd_pkg::KIND_CARVED),
                  started_q, "carve before start")
  `MCD_ASSERT_IMP(a_pick_valid, state_q == S_CARVE, cand_q[sel_dir_q], "picked a walled-off direction")

endmodule

FILE: rtl/mcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/maze_carver_dfs_top_tb.sv
// Self-checking testbench for the maze carver: directed table, then random maze phases.
module maze_carver_dfs_top_tb;
  import mcd_pkg::*;

  localparam int          ITEM_TARGET  = 1400;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          DIRECTED_N   = 24;

  // neighbor offsets, indexed by dir_e (up, down, left, right)
  localparam int STEP_DX [4] = '{0, 0, -2, 2};
  localparam int STEP_DY [4] = '{-2, 2, 0, 0};

  // sender idle percentage per random phase, cycled
  localparam int IDLE_PCT [4] = '{0, 55, 0, 26};

  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] target_x;
    logic [OUT_W-1:0] target_y;
    logic [OUT_W-1:0] between_x;
    logic [OUT_W-1:0] between_y;
  } carve_out_t;

  localparam carve_out_t OUT_START   = '{KIND_START, 6'd1, 6'd1, 6'd0, 6'd0};
  localparam carve_out_t OUT_DONE    = '{KIND_DONE, 6'd0, 6'd0, 6'd0, 6'd0};
  localparam carve_out_t OUT_NOSTART = '{KIND_NOSTART, 6'd0, 6'd0, 6'd0, 6'd0};
  localparam carve_out_t OUT_ANY     = '{KIND_START, 6'd0, 6'd0, 6'd0, 6'd0};

  typedef struct packed {
    logic             resize;
    logic [CFG_W-1:0] columns;
    logic [CFG_W-1:0] rows;
    cmd_e             cmd;
    logic [RND_W-1:0] rnd;
    logic             typed;
    carve_out_t       out;
  } directed_row_t;

  // typed rows: after reset, smallest grid, start beats; the rest go through the predictor
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd0,   1'b1, OUT_NOSTART},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd255, 1'b1, OUT_NOSTART},
    '{1'b1, 7'd3,   7'd3,   CMD_START, 8'h5a,  1'b1, OUT_START},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd0,   1'b1, OUT_DONE},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd255, 1'b1, OUT_DONE},
    '{1'b1, 7'd5,   7'd5,   CMD_START, 8'hff,  1'b1, OUT_START},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd0,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd1,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd255, 1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd128, 1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd7,   1'b0, OUT_ANY},
    '{1'b1, 7'd64,  7'd64,  CMD_START, 8'd0,   1'b1, OUT_START},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd255, 1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd0,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd3,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd2,   1'b0, OUT_ANY},
    // shrink mid-maze with out-of-range values
    '{1'b1, 7'd2,   7'd127, CMD_STEP,  8'd1,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd200, 1'b0, OUT_ANY},
    '{1'b1, 7'd0,   7'd65,  CMD_START, 8'h81,  1'b1, OUT_START},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd0,   1'b0, OUT_ANY},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd255, 1'b0, OUT_ANY},
    '{1'b1, 7'd64,  7'd3,   CMD_START, 8'd0,   1'b1, OUT_START},
    '{1'b0, 7'd0,   7'd0,   CMD_STEP,  8'd9,   1'b0, OUT_ANY},
    '{1'b1, 7'd127, 7'd1,   CMD_STEP,  8'd0,   1'b0, OUT_ANY}
  };

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 command_i      = 1'b0;
  logic [RND_W-1:0]     random_value_i = '0;
  logic                 result_valid_o;
  logic [1:0]           kind_o;
  logic [OUT_W-1:0]     target_x_o;
  logic [OUT_W-1:0]     target_y_o;
  logic [OUT_W-1:0]     between_x_o;
  logic [OUT_W-1:0]     between_y_o;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [PADDR_W-1:0]   paddr          = '0;
  logic [PDATA_W-1:0]   pwdata         = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor state
  logic [MAX_COLUMNS-1:0] open_rows [MAX_ROWS] = '{default: '0};
  int                     trail_x [$];
  int                     trail_y [$];
  logic                   maze_started = 1'b0;
  logic [CFG_W-1:0]       grid_columns = CFG_W'(64);
  logic [CFG_W-1:0]       grid_rows    = CFG_W'(64);

  carve_out_t  expected_q [$];
  int          mismatches      = 0;
  int          sent_items      = 0;
  int          sender_idle_pct = 0;
  int unsigned cycle_count     = 0;

  maze_carver_dfs_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .random_value_i (random_value_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .target_x_o     (target_x_o),
    .target_y_o     (target_y_o),
    .between_x_o    (between_x_o),
    .between_y_o    (between_y_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic log_mismatch(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  function automatic void push_trail(int x, int y);
    if (trail_x.size() < STACK_DEPTH) begin
      trail_x = {trail_x, x};
      trail_y = {trail_y, y};
    end
  endfunction

  // one accepted beat: updates the maze copy and returns the result it causes
  function automatic carve_out_t carve_step(cmd_e cmd, logic [RND_W-1:0] rnd);
    carve_out_t res;
    int cols, rows, cx, cy, nx, ny, d, found, pick;
    int cand_x [4];
    int cand_y [4];
    if (cmd == CMD_START) begin
      foreach (open_rows[y]) open_rows[y] = '0;
      open_rows[1][1] = 1'b1;
      trail_x.delete();
      trail_y.delete();
      push_trail(1, 1);
      maze_started = 1'b1;
      return OUT_START;
    end
    if (!maze_started) return OUT_NOSTART;
    cols = (grid_columns < 3) ? 3 : (grid_columns > MAX_COLUMNS) ? MAX_COLUMNS : grid_columns;
    rows = (grid_rows < 3) ? 3 : (grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows;
    while (trail_x.size() > 0) begin
      cx = trail_x.pop_back();
      cy = trail_y.pop_back();
      found = 0;
      for (d = int'(DIR_UP); d <= int'(DIR_RIGHT); d++) begin
        nx = cx + STEP_DX[d];
        ny = cy + STEP_DY[d];
        if (nx > 0 && nx < cols - 1 && ny > 0 && ny < rows - 1) begin
          if (!open_rows[ny][nx]) begin
            cand_x[found] = nx;
            cand_y[found] = ny;
            found++;
          end
        end
      end
      if (found > 0) begin
        pick = int'(rnd) % found;
        res.kind      = KIND_CARVED;
        res.target_x  = OUT_W'(cand_x[pick]);
        res.target_y  = OUT_W'(cand_y[pick]);
        res.between_x = OUT_W'((cx + cand_x[pick]) / 2);
        res.between_y = OUT_W'((cy + cand_y[pick]) / 2);
        open_rows[cand_y[pick]][cand_x[pick]] = 1'b1;
        open_rows[(cy + cand_y[pick]) / 2][(cx + cand_x[pick]) / 2] = 1'b1;
        push_trail(cx, cy);
        push_trail(cand_x[pick], cand_y[pick]);
        return res;
      end
    end
    return OUT_DONE;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size(int max_size);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return CFG_W'($urandom_range(3, 13));
    if (roll < 70) return CFG_W'($urandom_range(14, 40));
    if (roll < 82) return CFG_W'(max_size);
    if (roll < 91) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(max_size + 1, 127));
  endfunction

  // write, then read back; the register keeps only its low bits
  task automatic write_reg(reg_e idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_COLUMNS) grid_columns = value[CFG_W-1:0];
    else grid_rows = value[CFG_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(value[CFG_W-1:0])) begin
      log_mismatch($sformatf("reg %s read %0h, want %0h", idx.name(), prdata,
                             value[CFG_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every outstanding beat has answered
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic send_item(cmd_e cmd, logic [RND_W-1:0] rnd, logic typed, carve_out_t fixed);
    carve_out_t want;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    random_value_i <= rnd;
    do @(posedge clk_i); while (busy);
    want = carve_step(cmd, rnd);
    expected_q = {expected_q, (typed ? fixed : want)};
    sent_items++;
  endtask

  always @(posedge clk_i) begin
    carve_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat, kind %0d", kind_o));
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 8'(kind_o), 8'(want.kind));
        check_field("target_x", 8'(target_x_o), 8'(want.target_x));
        check_field("target_y", 8'(target_y_o), 8'(want.target_y));
        check_field("between_x", 8'(between_x_o), 8'(want.between_x));
        check_field("between_y", 8'(between_y_o), 8'(want.between_y));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int                 row;
    int                 phase;
    int                 steps;
    logic [PDATA_W-1:0] noise;
    directed_row_t      cur;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIRECTED_N; row++) begin
      cur = DIRECTED_ROWS[row];
      if (cur.resize) begin
        drain_results();
        write_reg(REG_COLUMNS, PDATA_W'(cur.columns));
        write_reg(REG_ROWS, PDATA_W'(cur.rows));
      end
      send_item(cur.cmd, cur.rnd, cur.typed, cur.out);
    end

    // random mazes: mostly a fresh start and a run of steps, now and then a stray start
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      drain_results();
      sender_idle_pct = IDLE_PCT[phase % 4];
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        noise = ($urandom_range(0, 1) != 0) ? PDATA_W'($urandom()) : '0;
        noise[CFG_W-1:0] = pick_size(MAX_COLUMNS);
        write_reg(REG_COLUMNS, noise);
        noise = ($urandom_range(0, 1) != 0) ? PDATA_W'($urandom()) : '0;
        noise[CFG_W-1:0] = pick_size(MAX_ROWS);
        write_reg(REG_ROWS, noise);
      end
      if ($urandom_range(0, 9) < 8) begin
        send_item(CMD_START, RND_W'($urandom_range(0, 255)), 1'b0, OUT_ANY);
      end
      steps = $urandom_range(4, 48);
      repeat (steps) begin
        if ($urandom_range(0, 99) < 2) begin
          send_item(CMD_START, RND_W'($urandom_range(0, 255)), 1'b0, OUT_ANY);
        end else begin
          send_item(CMD_STEP, RND_W'($urandom_range(0, 255)), 1'b0, OUT_ANY);
        end
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mcd_pkg.sv
rtl/mcd_ram.sv
rtl/maze_carver_dfs_top.sv
tb/sv/maze_carver_dfs_top_tb.sv
